/* rtl/core/shash_pkg.sv */
`timescale 1ns / 1ps

package shash_pkg;

   localparam int unsigned DIGEST_WORDS_DEF = 4;
   localparam int unsigned PERM_ROUNDS      = 12;
   localparam int unsigned ROUND_W          = $clog2(PERM_ROUNDS);
   localparam int unsigned WORD_W           = 64;
   localparam int unsigned BYTES_W          = 4;

   localparam logic [WORD_W-1:0] HASH_IV  = 64'h0040_0c00_0000_0100;
   localparam logic [7:0]        PAD_BYTE = 8'h80;
   localparam logic [WORD_W-1:0] PAD_ONLY = {PAD_BYTE, 56'h0};

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [4:0][WORD_W-1:0] sponge_type;

   // rotate right by a fixed amount
   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

endpackage

/* rtl/core/shash_round.sv */
`timescale 1ns / 1ps

module shash_round
   import shash_pkg::*;
(
   input  sponge_type               state_cur,
   input  logic [ROUND_W-1:0]       round_idx,
   output sponge_type               state_nxt
);

   word_type x0, x1, x2, x3, x4;
   word_type t0, t1, t2, t3, t4;
   word_type y0, y1, y2, y3, y4;
   word_type rc;

   // round constant is {15-r, r}
   assign rc = {{(WORD_W - 2 * ROUND_W){1'b0}}, ~round_idx, round_idx};

   always_comb begin
      // constant addition and first xor layer
      x0 = state_cur[0] ^ state_cur[4];
      x4 = state_cur[4] ^ state_cur[3];
      x2 = state_cur[2] ^ rc ^ state_cur[1];
      x1 = state_cur[1];
      x3 = state_cur[3];
      // chi-like sbox layer
      t0 = ~x0 & x1;
      t1 = ~x1 & x2;
      t2 = ~x2 & x3;
      t3 = ~x3 & x4;
      t4 = ~x4 & x0;
      y0 = x0 ^ t1;
      y1 = x1 ^ t2;
      y2 = x2 ^ t3;
      y3 = x3 ^ t4;
      y4 = x4 ^ t0;
      y1 = y1 ^ y0;
      y0 = y0 ^ y4;
      y3 = y3 ^ y2;
      y2 = ~y2;
      // linear diffusion
      state_nxt[0] = y0 ^ rotr(y0, 19) ^ rotr(y0, 28);
      state_nxt[1] = y1 ^ rotr(y1, 61) ^ rotr(y1, 39);
      state_nxt[2] = y2 ^ rotr(y2, 1)  ^ rotr(y2, 6);
      state_nxt[3] = y3 ^ rotr(y3, 10) ^ rotr(y3, 17);
      state_nxt[4] = y4 ^ rotr(y4, 7)  ^ rotr(y4, 41);
   end

endmodule

/* rtl/core/shash_pad.sv */
`timescale 1ns / 1ps

module shash_pad
   import shash_pkg::*;
(
   input  word_type             block_data,
   input  logic [BYTES_W-1:0]   valid_bytes,
   input  logic                 last_block,
   output word_type             absorb_word,
   output logic                 pad_more
);

   word_type padded;

   // byte i counts from the most significant end
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         if (BYTES_W'(i) < valid_bytes) begin
            padded[WORD_W-1-8*i -: 8] = block_data[WORD_W-1-8*i -: 8];
         end else if (BYTES_W'(i) == valid_bytes) begin
            padded[WORD_W-1-8*i -: 8] = PAD_BYTE;
         end else begin
            padded[WORD_W-1-8*i -: 8] = 8'h00;
         end
      end
   end

   // a full final block is absorbed whole, padding follows as its own block
   assign pad_more    = last_block && (valid_bytes >= BYTES_W'(8));
   assign absorb_word = (!last_block || pad_more) ? block_data : padded;

endmodule

/* rtl/core/sponge_hash_256_core.sv */
`timescale 1ns / 1ps

// sponge hash core (ascon-hash style, 320-bit state, 64-bit rate)
//
// req channel: one transfer per 64-bit message block, first byte in bits 63..56.
// req_last_block marks the final block; req_valid_bytes (0..15, above 8 as 8)
// counts its bytes and the core appends the padding. A message whose length is
// a multiple of eight bytes ends with a full or a zero-byte final transfer.
// rsp channel: DIGEST_WORDS transfers of 64 digest bits, rsp_last_word on the
// final one.
// timing: a single round unit is reused, one round per cycle. A non-final
// block holds req_stall high while its permutation runs. A final block runs its
// permutation (and a second one after a full eight-byte block), then each digest
// word costs one emit step with a permutation between words, then a permutation
// rebuilds the initial state from the iv before the next message is taken.
// reset: req_stall stays high while the initial state is computed.
// rsp_stall holds the digest word in its output register; the core waits in
// its emit step until the word is taken.
module sponge_hash_256_core
   import shash_pkg::*;
#(
   parameter int unsigned DIGEST_WORDS = DIGEST_WORDS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_W-1:0]    req_block_data,
   input  logic [BYTES_W-1:0]   req_valid_bytes,
   input  logic                 req_last_block,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_W-1:0]    rsp_digest_word,
   output logic                 rsp_last_word
);

   localparam int unsigned CNT_W = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PERM,
      S_EMIT
   } fsm_type;

   fsm_type              state_ff, state_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 final_ff, final_in;
   logic                 pad_pend_ff, pad_pend_in;
   sponge_type           sponge_ff, sponge_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   word_type             rsp_word_ff, rsp_word_in;
   logic                 rsp_last_ff, rsp_last_in;

   sponge_type           round_out;
   word_type             absorb_word;
   logic                 pad_more;
   logic                 req_xfer;
   logic                 emit_go;
   logic                 round_done;
   logic                 emit_last;

   // shared round unit
   shash_round u_round (
      .state_cur (sponge_ff),
      .round_idx (round_ff),
      .state_nxt (round_out)
   );

   // block padding
   shash_pad u_pad (
      .block_data  (req_block_data),
      .valid_bytes (req_valid_bytes),
      .last_block  (req_last_block),
      .absorb_word (absorb_word),
      .pad_more    (pad_more)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   // output register is free when empty or drained this cycle
   assign emit_go    = !rsp_valid_ff || !rsp_stall;
   assign round_done = (round_ff == ROUND_W'(PERM_ROUNDS - 1));
   assign emit_last  = (cnt_ff == CNT_W'(DIGEST_WORDS - 1));

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      cnt_in       = cnt_ff;
      final_in     = final_ff;
      pad_pend_in  = pad_pend_ff;
      sponge_in    = sponge_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               // xor the block into the rate word and start the rounds
               sponge_in[0] = sponge_ff[0] ^ absorb_word;
               final_in     = req_last_block;
               pad_pend_in  = pad_more;
               round_in     = ROUND_W'(12 - PERM_ROUNDS);
               cnt_in       = '0;
               state_in     = S_PERM;
            end
         end
         S_PERM: begin
            sponge_in = round_out;
            if (round_done) begin
               round_in = ROUND_W'(12 - PERM_ROUNDS);
               if (pad_pend_ff) begin
                  // padding-only block after a full final block
                  sponge_in[0] = round_out[0] ^ PAD_ONLY;
                  pad_pend_in  = 1'b0;
               end else if (final_ff) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               round_in = round_ff + ROUND_W'(1);
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = sponge_ff[0];
               rsp_last_in  = emit_last;
               state_in     = S_PERM;
               if (emit_last) begin
                  // rebuild the initial state from the iv
                  sponge_in = {64'h0, 64'h0, 64'h0, 64'h0, HASH_IV};
                  final_in  = 1'b0;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PERM;
         round_ff     <= ROUND_W'(12 - PERM_ROUNDS);
         cnt_ff       <= '0;
         final_ff     <= 1'b0;
         pad_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         // initial state is computed by the round unit after reset
         sponge_ff    <= {64'h0, 64'h0, 64'h0, 64'h0, HASH_IV};
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         cnt_ff       <= cnt_in;
         final_ff     <= final_in;
         pad_pend_ff  <= pad_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         sponge_ff    <= sponge_in;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_last_word   = rsp_last_ff;

`ifndef SYNTHESIS
   // every accepted block starts a permutation
   a_xfer_starts_perm: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_PERM))
      else $error("accepted block did not start the round sequence");

   // the last digest word leads to the rebuild of the initial state
   a_last_rebuilds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && emit_go && emit_last)
      |=> (state_ff == S_PERM && !final_ff && rsp_valid_ff && rsp_last_ff))
      else $error("final digest word not followed by state rebuild");

   // a pending padding block only exists within a final block
   a_pad_in_final: assert property (@(posedge clock) disable iff (reset)
      pad_pend_ff |-> (final_ff && state_ff == S_PERM))
      else $error("padding block pending outside a final block");

   // round counter is rewound whenever the core is outside the permutation
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_PERM) |-> (round_ff == ROUND_W'(12 - PERM_ROUNDS)))
      else $error("round counter not rewound outside the permutation");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import shash_pkg::*;

   localparam int DIGEST_N    = DIGEST_WORDS_DEF;
   localparam int TARGET_BLKS = 430;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 80;

   typedef struct packed {
      word_type digest;
      logic     is_last;
   } digest_exp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [WORD_W-1:0]   req_block_data = '0;
   logic [BYTES_W-1:0]  req_valid_bytes = '0;
   logic                req_last_block = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [WORD_W-1:0]   rsp_digest_word;
   logic                rsp_last_word;

   sponge_hash_256_core #(
      .DIGEST_WORDS(DIGEST_N)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_block_data(req_block_data),
      .req_valid_bytes(req_valid_bytes),
      .req_last_block(req_last_block),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_digest_word(rsp_digest_word),
      .rsp_last_word(rsp_last_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted sponge state and digest words still owed by the core
   sponge_type     hash_state;
   sponge_type     hash_init;
   digest_exp_type pending_digests[$];

   int errors          = 0;
   int blocks_sent     = 0;
   int messages_hashed = 0;
   int full_tails      = 0;
   int digests_checked = 0;
   int burst_left      = 0;
   bit steady_send     = 1'b0;

   function automatic word_type ror64(input word_type x, input int n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic sponge_type permute12(input sponge_type s);
      word_type x0, x1, x2, x3, x4;
      word_type t0, t1, t2, t3, t4;
      logic [7:0] rc;
      for (int r = 0; r < PERM_ROUNDS; r++) begin
         rc = 8'(((15 - r) << 4) | r);
         x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
         x2 ^= {56'h0, rc};
         // substitution layer, bitsliced
         x0 ^= x4; x4 ^= x3; x2 ^= x1;
         t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3;
         t3 = ~x3 & x4; t4 = ~x4 & x0;
         x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
         x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
         // linear diffusion per word
         s[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
         s[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
         s[2] = x2 ^ ror64(x2, 1)  ^ ror64(x2, 6);
         s[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
         s[4] = x4 ^ ror64(x4, 7)  ^ ror64(x4, 41);
      end
      return s;
   endfunction

   function automatic void absorb_block(input word_type blk);
      hash_state[0] ^= blk;
      hash_state = permute12(hash_state);
   endfunction

   // final block: pad, absorb, squeeze the digest, back to the initial state
   function automatic void predict_digest(input word_type data,
                                          input logic [BYTES_W-1:0] nbytes);
      word_type pad_blk;
      word_type keep;
      if (nbytes >= 8) begin
         absorb_block(data);
         pad_blk = PAD_ONLY;
         full_tails++;
      end else if (nbytes == 0) begin
         pad_blk = PAD_ONLY;
      end else begin
         keep    = ~64'h0 << (WORD_W - 8 * nbytes);
         pad_blk = (data & keep) | (PAD_ONLY >> (8 * nbytes));
      end
      absorb_block(pad_blk);
      for (int k = 0; k < DIGEST_N; k++) begin
         if (k > 0)
            hash_state = permute12(hash_state);
         pending_digests.push_back(digest_exp_type'{digest: hash_state[0],
                                                    is_last: (k == DIGEST_N - 1)});
      end
      hash_state = hash_init;
      messages_hashed++;
   endfunction

   // called in the time step of a rising edge; returns at the accepting edge
   task automatic send_block(input word_type data, input logic [BYTES_W-1:0] nbytes,
                             input logic last);
      req_valid       <= 1'b1;
      req_block_data  <= data;
      req_valid_bytes <= nbytes;
      req_last_block  <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      blocks_sent++;
      if (last)
         predict_digest(data, nbytes);
      else
         absorb_block(data);
   endtask

   // bursts of random length, random gaps between them
   task automatic pace_sender();
      if (steady_send)
         return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 10);
      end
   endtask

   // hold the sender off until every owed digest word has come out
   task automatic wait_for_digests();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_digests.size() != 0);
   endtask

   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_empty_message();
      send_block('0, 4'd0, 1'b1);
      pace_sender();
      // tail data must be ignored when no bytes are valid
      send_block('1, 4'd0, 1'b1);
      pace_sender();
   endtask

   task automatic test_partial_tail();
      for (int n = 1; n < 8; n++) begin
         send_block((n % 2) ? '1 : rand_word(), BYTES_W'(n), 1'b1);
         pace_sender();
      end
   endtask

   task automatic test_full_tail();
      send_block('1, 4'd8, 1'b1);
      pace_sender();
      // counts above eight saturate
      send_block(64'h0123_4567_89ab_cdef, 4'd9, 1'b1);
      pace_sender();
      send_block('0, 4'd15, 1'b1);
      pace_sender();
   endtask

   task automatic test_multi_block();
      // byte count is ignored on the non-final blocks
      send_block('0, 4'd15, 1'b0);
      send_block('1, 4'd3, 1'b0);
      send_block(rand_word(), 4'd4, 1'b1);
      wait_for_digests();
      send_block(rand_word(), 4'd8, 1'b0);
      send_block(rand_word(), 4'd0, 1'b1);
      pace_sender();
   endtask

   task automatic test_random_messages();
      int n_body;
      int vb;
      while (blocks_sent < TARGET_BLKS) begin
         steady_send = ($urandom_range(0, 5) == 0);
         n_body = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                              : $urandom_range(0, 4);
         for (int i = 0; i < n_body; i++) begin
            send_block(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
            pace_sender();
         end
         vb = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
         send_block(rand_word(), 4'(vb), 1'b1);
         if ($urandom_range(0, 11) == 0)
            wait_for_digests();
         else
            pace_sender();
      end
      steady_send = 1'b0;
   endtask

   // receiver: 16-bit stall pattern replayed, reloaded when the phase wraps, sometimes no stall at all
   logic [15:0] stall_pattern = '0;
   int          stall_phase   = 0;

   always @(posedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern <= '0;
            1:       stall_pattern <= 16'($urandom) | 16'($urandom);
            default: stall_pattern <= 16'($urandom);
         endcase
      end
      rsp_stall   <= stall_pattern[stall_phase % 16];
      stall_phase <= (stall_phase + 1) % 64;
   end

   // digest checker
   always @(posedge clock) begin
      digest_exp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_digests.size() == 0) begin
            $display("%0t: unexpected digest transfer %h last %b", $time,
                     rsp_digest_word, rsp_last_word);
            errors++;
         end else begin
            want = pending_digests.pop_front();
            digests_checked++;
            if (rsp_digest_word !== want.digest) begin
               $display("%0t: digest word mismatch: expected %h actual %h", $time,
                        want.digest, rsp_digest_word);
               errors++;
            end
            if (rsp_last_word !== want.is_last) begin
               $display("%0t: last word flag mismatch: expected %b actual %b", $time,
                        want.is_last, rsp_last_word);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("FAIL sponge_hash_256_core");
         $finish;
      end
   end

   initial begin
      hash_init    = '0;
      hash_init[0] = HASH_IV;
      hash_init    = permute12(hash_init);
      hash_state   = hash_init;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_message();
      test_partial_tail();
      test_full_tail();
      test_multi_block();
      test_random_messages();

      wait_for_digests();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("hashed %0d messages from %0d blocks (%0d with a full final block)",
               messages_hashed, blocks_sent, full_tails);
      $display("checked %0d digest words, %0d mismatches", digests_checked, errors);
      if (errors == 0 && pending_digests.size() == 0) begin
         $display("PASS sponge_hash_256_core");
      end else begin
         if (pending_digests.size() != 0)
            $display("%0d digest words never arrived", pending_digests.size());
         $display("FAIL sponge_hash_256_core");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/shash_pkg.sv
rtl/core/shash_round.sv
rtl/core/shash_pad.sv
rtl/core/sponge_hash_256_core.sv
dv/tb_top.sv
